@@ design/epht_pkg.sv @@
// ----------------------------------------------------------------------------
// Edge pair hash table package
// Shared types, command codes and constants of the edge pair hash table unit.
// ----------------------------------------------------------------------------
package epht_pkg;

	// Vertex index width; a pair hashes to (low << 8) ^ high in 32 bits at most.
	localparam int VERTEX_BITS = 16;
	localparam int HASH_W      = (VERTEX_BITS + 8 > 32) ? 32 : VERTEX_BITS + 8;
	localparam int ENTRY_W     = 9;

	localparam int SLOT_COUNT_DEFAULT  = 1024;
	localparam int ENTRY_COUNT_DEFAULT = 512;

	// Probe sequence: slot = 5*slot + 1 + perturb, perturb >>= 5.
	localparam int PROBE_SHIFT = 5;
	localparam int PROBE_EXTRA = 8;

	// Command codes of an input item
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]             cmd;
		logic [VERTEX_BITS-1:0] vertex_a;
		logic [VERTEX_BITS-1:0] vertex_b;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [ENTRY_W-1:0] entry_number;
		logic               table_full;
	} out_item_t;

	// Kind of result captured by the datapath
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FULL,
		RES_NEW,
		RES_HIT
	} res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic clr_step;
		logic insert_wr;
		logic advance;
		logic save_ent;
		logic set_res;
		res_t res;
		logic load_out;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic full;
		logic slot_used;
		logic edge_match;
		logic last_probe;
		logic clr_last;
	} stat_t;

endpackage

@@ design/epht_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module epht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/epht_dp.sv @@
// ----------------------------------------------------------------------------
// Edge pair hash table datapath
// Pair ordering and hashing, probe sequence, slot map and edge store
// memories, edge counter, clear sweep and result registers.
// ----------------------------------------------------------------------------
module epht_dp #(
	parameter int SLOT_COUNT  = 1024,
	parameter int ENTRY_COUNT = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  epht_pkg::in_item_t req_item,
	input  epht_pkg::ctl_t     ctl,
	output epht_pkg::stat_t    st,
	output epht_pkg::out_item_t rsp_item
);
	import epht_pkg::*;

	localparam int SIW         = $clog2(SLOT_COUNT);
	localparam int EIW         = $clog2(ENTRY_COUNT);
	localparam int LIMIT       = (ENTRY_COUNT < SLOT_COUNT) ? ENTRY_COUNT : SLOT_COUNT;
	localparam int CW          = $clog2(LIMIT + 1);
	localparam int PROBE_LIMIT = SLOT_COUNT + PROBE_EXTRA;
	localparam int PW          = $clog2(PROBE_LIMIT);
	localparam int MW          = EIW + 1;
	localparam int EW          = 2 * VERTEX_BITS;

	logic [VERTEX_BITS-1:0] lo_d, hi_d, lo_q, hi_q;
	logic [HASH_W-1:0]      hash_d, perturb_q;
	logic [SIW-1:0]         slot_q, slot_nxt, clr_q;
	logic [PW-1:0]          probe_q;
	logic [EIW-1:0]         ent_q, res_entry_q;
	logic [CW-1:0]          count_q;
	logic                   res_found_q, res_full_q;
	out_item_t              rsp_q;

	logic                   map_we;
	logic [SIW-1:0]         map_waddr;
	logic [MW-1:0]          map_wdata, map_rd;
	logic [EW-1:0]          edge_rd;

	// Order the pair and hash it
	always_comb begin
		if (req_item.vertex_a < req_item.vertex_b) begin
			lo_d = req_item.vertex_a;
			hi_d = req_item.vertex_b;
		end else begin
			lo_d = req_item.vertex_b;
			hi_d = req_item.vertex_a;
		end
		hash_d = HASH_W'({lo_d, 8'h00}) ^ HASH_W'(hi_d);
	end

	// Next probe slot: 5*slot + 1 + perturb, masked to the table size
	assign slot_nxt = SIW'({slot_q, 2'b00}) + slot_q + SIW'(1) + perturb_q[SIW-1:0];

	assign map_we    = ctl.clr_step | ctl.insert_wr;
	assign map_waddr = ctl.clr_step ? clr_q : slot_q;
	assign map_wdata = ctl.clr_step ? '0 : {1'b1, EIW'(count_q)};

	epht_ram #(
		.WIDTH (MW),
		.DEPTH (SLOT_COUNT)
	) u_slot_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (slot_q),
		.rdata (map_rd)
	);

	epht_ram #(
		.WIDTH (EW),
		.DEPTH (ENTRY_COUNT)
	) u_edge_store (
		.clk   (clk),
		.we    (ctl.insert_wr),
		.waddr (EIW'(count_q)),
		.wdata ({lo_q, hi_q}),
		.raddr (map_rd[EIW-1:0]),
		.rdata (edge_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (ctl.clr_step) begin
				count_q <= '0;
				clr_q   <= clr_q + SIW'(1);
			end else if (ctl.insert_wr) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lo_q      <= lo_d;
			hi_q      <= hi_d;
			slot_q    <= hash_d[SIW-1:0];
			perturb_q <= hash_d;
			probe_q   <= '0;
		end else if (ctl.advance) begin
			slot_q    <= slot_nxt;
			perturb_q <= perturb_q >> PROBE_SHIFT;
			probe_q   <= probe_q + PW'(1);
		end
		if (ctl.save_ent) begin
			ent_q <= map_rd[EIW-1:0];
		end
		if (ctl.set_res) begin
			case (ctl.res)
				RES_FULL: begin
					res_found_q <= 1'b0;
					res_entry_q <= '0;
					res_full_q  <= 1'b1;
				end
				RES_NEW: begin
					res_found_q <= 1'b1;
					res_entry_q <= EIW'(count_q);
					res_full_q  <= 1'b0;
				end
				RES_HIT: begin
					res_found_q <= 1'b1;
					res_entry_q <= ent_q;
					res_full_q  <= 1'b0;
				end
				default: begin
					res_found_q <= 1'b0;
					res_entry_q <= '0;
					res_full_q  <= 1'b0;
				end
			endcase
		end
		if (ctl.load_out) begin
			rsp_q.found        <= res_found_q;
			rsp_q.entry_number <= ENTRY_W'(res_entry_q);
			rsp_q.table_full   <= res_full_q;
		end
	end

	assign st.full       = (count_q >= CW'(LIMIT));
	assign st.slot_used  = map_rd[MW-1];
	assign st.edge_match = (edge_rd == {lo_q, hi_q});
	assign st.last_probe = (probe_q == PW'(PROBE_LIMIT - 1));
	assign st.clr_last   = (clr_q == SIW'(SLOT_COUNT - 1));

	assign rsp_item = rsp_q;

`ifndef SYNTHESIS
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert_wr |-> !st.full)
		else $error("edge stored into a full table");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert_wr |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("edge count did not advance on store");

	a_sweep_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.clr_step && st.clr_last) |=> (count_q == '0 && clr_q == '0))
		else $error("clear sweep left count or sweep address nonzero");
`endif

endmodule

@@ design/epht_ctrl.sv @@
// ----------------------------------------------------------------------------
// Edge pair hash table controller
// Sequences the clear sweep, the probe loop and the result hand-off.
// ----------------------------------------------------------------------------
module epht_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [1:0]      req_cmd,
	output logic            req_stall,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	input  epht_pkg::stat_t st,
	output epht_pkg::ctl_t  ctl
);
	import epht_pkg::*;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_SLOT_RD,
		ST_SLOT_CHK,
		ST_EDGE_CHK,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   op_insert_q;
	logic   clr_reply_q;
	logic   rsp_valid_q;
	logic   accept;

	assign accept    = (state_q == ST_IDLE) && req_valid;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		ctl     = '0;
		ctl.res = RES_ZERO;
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				ctl.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = clr_reply_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					ctl.load    = 1'b1;
					ctl.set_res = 1'b1;
					unique case (req_cmd)
						CMD_INSERT: begin
							if (st.full) begin
								ctl.res = RES_FULL;
								state_d = ST_DONE;
							end else begin
								state_d = ST_SLOT_RD;
							end
						end
						CMD_LOOKUP: state_d = ST_SLOT_RD;
						CMD_CLEAR:  state_d = ST_SWEEP;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_SLOT_RD: begin
				state_d = ST_SLOT_CHK;
			end
			ST_SLOT_CHK: begin
				if (!st.slot_used) begin
					if (op_insert_q) begin
						ctl.insert_wr = 1'b1;
						ctl.set_res   = 1'b1;
						ctl.res       = RES_NEW;
					end
					state_d = ST_DONE;
				end else if (op_insert_q) begin
					ctl.advance = 1'b1;
					state_d     = st.last_probe ? ST_DONE : ST_SLOT_RD;
				end else begin
					ctl.save_ent = 1'b1;
					state_d      = ST_EDGE_CHK;
				end
			end
			ST_EDGE_CHK: begin
				if (st.edge_match) begin
					ctl.set_res = 1'b1;
					ctl.res     = RES_HIT;
					state_d     = ST_DONE;
				end else begin
					ctl.advance = 1'b1;
					state_d     = st.last_probe ? ST_DONE : ST_SLOT_RD;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_SWEEP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			op_insert_q <= 1'b0;
			clr_reply_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_insert_q <= (req_cmd == CMD_INSERT);
				clr_reply_q <= (req_cmd == CMD_CLEAR);
			end
			if (ctl.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("second item taken while one is in progress");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> rsp_valid)
		else $error("loaded result not presented");
`endif

endmodule

@@ design/edge_pair_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// Edge pair hash table unit
// Open addressing hash table of undirected edges keyed by vertex pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_item) takes one item: insert
//   a pair, look up a pair or clear the table. Response channel (rsp_valid /
//   rsp_stall / rsp_item) returns exactly one item per request item.
//   The pair is ordered (low, high), hashed as (low << 8) ^ high and probed
//   with 5*slot + 1 + perturb, perturb shifted right by 5 per probe.
// Sequence of an item:
//   insert or lookup: each probe reads the slot map; an insert stores the pair
//   in the first empty slot, a lookup reads the edge store for each used slot
//   and stops on a match or at an empty slot. clear: the slot map is swept.
//   Refused insert (table full) or unused code: answered without a probe.
//   No new item is taken until the current result is in the output register.
// Reset: the slot map is swept empty, one slot per cycle, over all SLOT_COUNT
//   slots; req_stall stays high during the sweep.
// Stall: a finished result waits in the output register while rsp_stall is
//   high; the next request item is still taken and worked on, and its result
//   holds in the datapath until the output register frees up.
// ----------------------------------------------------------------------------
module edge_pair_hash_table_unit #(
	parameter int SLOT_COUNT  = epht_pkg::SLOT_COUNT_DEFAULT,
	parameter int ENTRY_COUNT = epht_pkg::ENTRY_COUNT_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  epht_pkg::in_item_t  req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output epht_pkg::out_item_t rsp_item
);
	import epht_pkg::*;

	ctl_t  ctl;
	stat_t st;

	// Controller: sweep, probe loop sequencing, response hand-off
	epht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req_item.cmd),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.st        (st),
		.ctl       (ctl)
	);

	// Datapath: hashing, memories, edge counter, result registers
	epht_dp #(
		.SLOT_COUNT  (SLOT_COUNT),
		.ENTRY_COUNT (ENTRY_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_item (req_item),
		.ctl      (ctl),
		.st       (st),
		.rsp_item (rsp_item)
	);

`ifndef SYNTHESIS
	a_full_excludes_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_item.found && rsp_item.table_full))
		else $error("response reports both stored and table full");
`endif

endmodule
